// ===== design/bqss_pkg.sv =====
// Shared types and constants for the bounded queue server scheduler.
// Used by bqss_queue and bounded_queue_server_scheduler_unit; no dependencies.
package bqss_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W        = 16;
	localparam int ARR_W       = 32;
	localparam int DUR_W       = 32;
	localparam int TIME_W      = 48;
	localparam int LIMIT_W     = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam logic FUNC_ARRIVAL = 1'b0;
	localparam logic FUNC_FLUSH   = 1'b1;

	typedef struct packed {
		logic             func;
		logic [ID_W-1:0]  job_id;
		logic [ARR_W-1:0] arrival_time;
		logic [DUR_W-1:0] service_time;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]   done_id;
		logic [TIME_W-1:0] completion_time;
		logic              rejected;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [ARR_W-1:0] arrival;
		logic [DUR_W-1:0] duration;
	} wait_entry_t;

	typedef struct packed {
		logic        push;
		logic        pop;
		wait_entry_t wdata;
	} q_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		wait_entry_t      head;
	} q_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_HEAD,
		S_RUN,
		S_DECIDE,
		S_LAST
	} state_t;

endpackage

// ===== design/bqss_queue.sv =====
// Waiting-job FIFO: entry memory with registered head read, head/tail pointers, count.
// Depends on bqss_pkg.
module bqss_queue
	import bqss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  q_ctrl_t ctrl,
	output q_stat_t stat
);

	wait_entry_t      mem [QUEUE_DEPTH];
	wait_entry_t      head_data_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
		else r = p + PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (ctrl.push) mem[tail_q] <= ctrl.wdata;
		head_data_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) tail_q <= ptr_inc(tail_q);
			if (ctrl.pop) head_q <= ptr_inc(head_q);
			if (ctrl.push && !ctrl.pop) count_q <= count_q + CNT_W'(1);
			else if (ctrl.pop && !ctrl.push) count_q <= count_q - CNT_W'(1);
		end
	end

	assign stat.count = count_q;
	assign stat.head  = head_data_q;

endmodule

// ===== design/bounded_queue_server_scheduler_unit.sv =====
// Top level of the single-server FIFO scheduler with tail drop.
// Depends on bqss_pkg and bqss_queue.
//
//   channel  | signals                         | direction | transfer when
//   item     | item_valid, item_stall, item    | in        | item_valid & !item_stall
//   result   | result_valid, result_stall, res | out       | result_valid & !result_stall
//   cfg      | cfg_valid, cfg_ready, cfg_data  | in        | cfg_valid & cfg_ready
//
// One item at a time. With an empty queue the steps are accept, count check, decide, hand-off;
// each waiting job that starts adds a count check, a head start check and an add; one that
// fails its start check adds that check. The registered head read of the memory paces the drain.
// Reset leaves the queue empty, server free at 0, queue_limit 16. A stalled result
// output holds the sequencer only when another result must be handed over.
module bounded_queue_server_scheduler_unit
	import bqss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	state_t             state_q, state_d;
	item_t              item_q;
	logic [LIMIT_W-1:0] queue_limit_q;
	logic [TIME_W-1:0]  free_q;
	logic [TIME_W-1:0]  start_q;
	result_t            pend_q;
	logic               pend_valid_q;
	result_t            out_q;
	logic               out_valid_q;

	q_ctrl_t q_ctrl;
	q_stat_t q_stat;

	logic              out_room;
	logic              slot_ok;
	logic              out_load;
	result_t           out_next;
	logic              pend_load;
	logic              pend_clr;
	result_t           pend_next;
	logic              free_load;
	logic [TIME_W-1:0] free_next;
	logic              start_load;
	logic [TIME_W-1:0] start_next;
	logic [TIME_W-1:0] arr_ext;
	logic [TIME_W-1:0] head_arr_ext;
	logic [TIME_W:0]   run_sum;
	logic [TIME_W-1:0] run_t;
	logic [TIME_W-1:0] new_t;
	logic              room;
	logic              accept;

	bqss_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.stat   (q_stat)
	);

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign out_room     = !out_valid_q || !result_stall;
	assign slot_ok      = !pend_valid_q || out_room;
	assign arr_ext      = TIME_W'(item_q.arrival_time);
	assign head_arr_ext = TIME_W'(q_stat.head.arrival);
	assign run_sum      = {1'b0, start_q} + (TIME_W + 1)'(q_stat.head.duration);
	assign run_t        = run_sum[TIME_W] ? '1 : run_sum[TIME_W-1:0];
	assign new_t        = arr_ext + TIME_W'(item_q.service_time);

	always_comb begin
		if (32'(queue_limit_q) > QUEUE_DEPTH) room = (32'(q_stat.count) < QUEUE_DEPTH);
		else room = (32'(q_stat.count) < 32'(queue_limit_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		q_ctrl.push  = 1'b0;
		q_ctrl.pop   = 1'b0;
		q_ctrl.wdata = '{id: item_q.job_id, arrival: item_q.arrival_time,
		                 duration: item_q.service_time};
		out_load     = 1'b0;
		out_next     = pend_q;
		out_next.last = 1'b0;
		pend_load    = 1'b0;
		pend_clr     = 1'b0;
		pend_next    = '0;
		free_load    = 1'b0;
		free_next    = run_t;
		start_load   = 1'b0;
		start_next   = (head_arr_ext > free_q) ? head_arr_ext : free_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = (q_stat.count != '0) ? S_HEAD : S_DECIDE;
			end
			S_HEAD: begin
				if (item_q.func == FUNC_FLUSH ||
				    (q_stat.head.arrival <= item_q.arrival_time && free_q <= arr_ext)) begin
					start_load = 1'b1;
					state_d    = S_RUN;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_RUN: begin
				if (slot_ok) begin
					out_load   = pend_valid_q;
					pend_load  = 1'b1;
					pend_next  = '{done_id: q_stat.head.id, completion_time: run_t,
					               rejected: 1'b0, last: 1'b0};
					free_load  = 1'b1;
					q_ctrl.pop = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_DECIDE: begin
				if (item_q.func == FUNC_FLUSH) begin
					state_d = S_LAST;
				end else if (q_stat.count == '0 && free_q <= arr_ext) begin
					if (slot_ok) begin
						out_load  = pend_valid_q;
						pend_load = 1'b1;
						pend_next = '{done_id: item_q.job_id, completion_time: new_t,
						              rejected: 1'b0, last: 1'b0};
						free_load = 1'b1;
						free_next = new_t;
						state_d   = S_LAST;
					end
				end else if (room) begin
					q_ctrl.push = 1'b1;
					state_d     = S_LAST;
				end else begin
					if (slot_ok) begin
						out_load  = pend_valid_q;
						pend_load = 1'b1;
						pend_next = '{done_id: item_q.job_id, completion_time: '0,
						              rejected: 1'b1, last: 1'b0};
						state_d   = S_LAST;
					end
				end
			end
			S_LAST: begin
				if (!pend_valid_q) begin
					state_d = S_IDLE;
				end else if (out_room) begin
					out_load      = 1'b1;
					out_next.last = 1'b1;
					pend_clr      = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= LIMIT_RESET;
			free_q        <= '0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) queue_limit_q <= cfg_data;
			if (free_load) free_q <= free_next;
			if (pend_load) pend_valid_q <= 1'b1;
			else if (pend_clr) pend_valid_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (start_load) start_q <= start_next;
		if (pend_load) pend_q <= pend_next;
		if (out_load) out_q <= out_next;
	end

endmodule
